// ===== rtl/rit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rit_pkg: shared types and constants for the repeating interval timer
// Command and result item layouts, command codes, register indexes.
// ----------------------------------------------------------------------------
package rit_pkg;

    localparam int TIME_WIDTH_DEF   = 32;
    localparam int REPEAT_WIDTH_DEF = 16;
    localparam int CFG_INDEX_W      = 2;
    localparam int CFG_DATA_W       = 32;
    localparam int TOTAL_W          = 48;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_PAUSE = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIME_SOURCE  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] delta_game;
        logic [31:0] delta_real;
    } cmd_item_t;

    typedef struct packed {
        logic                fired;
        logic                is_running;
        logic                is_live;
        logic                is_paused;
        logic [15:0]         repeats_remaining;
        logic [TOTAL_W-1:0]  total_time_left;
    } res_item_t;

    typedef struct packed {
        logic fired;
        logic is_running;
        logic is_live;
        logic is_paused;
    } rit_flags_t;

endpackage

// ===== rtl/rit_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rit_core: timer state and command decode
// Holds the config registers and timer state, applies one command per
// accepted item and captures the post-command snapshot for the result path.
// ----------------------------------------------------------------------------
module rit_core #(
    parameter int TIME_WIDTH   = rit_pkg::TIME_WIDTH_DEF,
    parameter int REPEAT_WIDTH = rit_pkg::REPEAT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              take,
    input  rit_pkg::cmd_item_t                item,
    input  logic                              cfg_we,
    input  logic [rit_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rit_pkg::CFG_DATA_W-1:0]    cfg_data,
    output rit_pkg::rit_flags_t               flags_reg,
    output logic [REPEAT_WIDTH-1:0]           rep_reg,
    output logic [TIME_WIDTH-1:0]             base_reg,
    output logic [TIME_WIDTH-1:0]             interval_reg
);
    import rit_pkg::*;

    localparam int TW = TIME_WIDTH;
    localparam int RW = REPEAT_WIDTH;

    // remaining time is signed, TW+1 bits, kept as a raw vector
    logic [TW:0]   rem_reg;
    logic [TW:0]   rem_next;
    logic          running_reg;
    logic          running_next;
    logic          valid_reg;
    logic          valid_next;
    logic [RW-1:0] repeats_reg;
    logic [RW-1:0] repeats_next;
    logic          source_reg;

    logic [TW-1:0] delta;
    logic [TW+1:0] diff;
    logic [TW:0]   sub_sat;
    logic [TW:0]   reload;
    logic          expired;
    logic [RW-1:0] rep_dec;
    logic          fired;

    always_comb
    begin
        delta   = source_reg ? TW'(item.delta_real) : TW'(item.delta_game);
        diff    = {rem_reg[TW], rem_reg} - {2'b00, delta};
        // clamp at the most negative value
        sub_sat = (diff[TW+1] != diff[TW]) ? {1'b1, {TW{1'b0}}} : diff[TW:0];
        expired = sub_sat[TW] || (sub_sat == '0);
        reload  = sub_sat + {1'b0, interval_reg};
        rep_dec = repeats_reg - 1'b1;
    end

    always_comb
    begin
        rem_next     = rem_reg;
        running_next = running_reg;
        valid_next   = valid_reg;
        repeats_next = repeats_reg;
        fired        = 1'b0;
        case (op_t'(item.operation))
            OP_TICK:
            begin
                if (running_reg && valid_reg)
                begin
                    rem_next = sub_sat;
                    if (expired)
                    begin
                        fired = 1'b1;
                        if (repeats_reg != '0)
                        begin
                            repeats_next = rep_dec;
                            if (rep_dec == '0)
                            begin
                                valid_next   = 1'b0;
                                running_next = 1'b0;
                                rem_next     = '0;
                            end
                            else
                            begin
                                rem_next = reload;
                            end
                        end
                        else
                        begin
                            rem_next = reload;
                        end
                    end
                end
            end
            OP_START:
            begin
                if (valid_reg && !running_reg)
                begin
                    if (rem_reg == '0)
                    begin
                        rem_next = {1'b0, interval_reg};
                    end
                    running_next = 1'b1;
                end
            end
            OP_PAUSE:
            begin
                running_next = 1'b0;
            end
            OP_STOP:
            begin
                running_next = 1'b0;
                rem_next     = '0;
            end
            default:
            begin
                running_next = running_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg      <= '0;
            running_reg  <= 1'b0;
            valid_reg    <= 1'b1;
            repeats_reg  <= '0;
            interval_reg <= '0;
            source_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INTERVAL:     interval_reg <= TW'(cfg_data);
                CFG_REPEAT_COUNT: repeats_reg  <= RW'(cfg_data[15:0]);
                CFG_TIME_SOURCE:  source_reg   <= cfg_data[0];
                default:          source_reg   <= source_reg;
            endcase
        end
        else if (take)
        begin
            rem_reg     <= rem_next;
            running_reg <= running_next;
            valid_reg   <= valid_next;
            repeats_reg <= repeats_next;
        end
    end

    // post-command snapshot for the result path
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            flags_reg.fired      <= fired;
            flags_reg.is_running <= running_next;
            flags_reg.is_live    <= valid_next;
            flags_reg.is_paused  <= !running_next && (rem_next != '0);
            rep_reg              <= repeats_next;
            base_reg             <= rem_next[TW] ? '0 : rem_next[TW-1:0];
        end
    end

endmodule

// ===== rtl/rit_total.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rit_total: time-left computation
// Stage 2 multiplies further periods by the interval, stage 3 adds the current
// remaining time, saturates to 48 bits (zero if the repeat count is zero) and forms the result item.
// ----------------------------------------------------------------------------
module rit_total #(
    parameter int TIME_WIDTH   = rit_pkg::TIME_WIDTH_DEF,
    parameter int REPEAT_WIDTH = rit_pkg::REPEAT_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      en2,
    input  logic                      en3,
    input  rit_pkg::rit_flags_t       flags_in,
    input  logic [REPEAT_WIDTH-1:0]   rep_in,
    input  logic [TIME_WIDTH-1:0]     base_in,
    input  logic [TIME_WIDTH-1:0]     interval,
    output rit_pkg::res_item_t        item_reg
);
    import rit_pkg::*;

    localparam int TW     = TIME_WIDTH;
    localparam int RW     = REPEAT_WIDTH;
    localparam int PW     = TW + RW;
    localparam int SUM_W  = (PW + 1 > TOTAL_W + 1) ? PW + 1 : TOTAL_W + 1;

    logic [RW-1:0]    n;
    logic [PW-1:0]    prod;
    logic [PW-1:0]    prod_reg;
    logic [TW-1:0]    base2_reg;
    logic [RW-1:0]    rep2_reg;
    logic             zero2_reg;
    rit_flags_t       flags2_reg;
    logic [SUM_W-1:0] sum;
    logic             sat;
    logic [TOTAL_W-1:0] total;

    always_comb
    begin
        n    = rep_in - 1'b1;
        prod = {{TW{1'b0}}, n} * {{RW{1'b0}}, interval};
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            prod_reg   <= prod;
            base2_reg  <= base_in;
            rep2_reg   <= rep_in;
            zero2_reg  <= (rep_in == '0);
            flags2_reg <= flags_in;
        end
    end

    always_comb
    begin
        sum   = SUM_W'(base2_reg) + SUM_W'(prod_reg);
        sat   = |sum[SUM_W-1:TOTAL_W];
        if (zero2_reg)
            total = '0;
        else if (sat)
            total = '1;
        else
            total = sum[TOTAL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            item_reg.fired             <= flags2_reg.fired;
            item_reg.is_running        <= flags2_reg.is_running;
            item_reg.is_live           <= flags2_reg.is_live;
            item_reg.is_paused         <= flags2_reg.is_paused;
            item_reg.repeats_remaining <= 16'(rep2_reg);
            item_reg.total_time_left   <= total;
        end
    end

endmodule

// ===== rtl/repeating_interval_timer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeating_interval_timer: repeating countdown timer with repeat count
//
//   channel  direction  handshake             payload
//   cmd      in         cmd_valid/cmd_stall   cmd_item (operation, deltas)
//   res      out        res_valid/res_stall   res_item (flags, repeats, time)
//   cfg      in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One command per cycle while cmd_stall is low; a taken command passes the
// three registers in order before its result is valid: state/snapshot,
// multiply, add and saturate.
// Each stage moves when the one after it is empty or moving, so two more
// commands at most are taken while a result waits; then cmd_stall follows res_stall.
// Reset clears the timer state and config registers and marks the timer live; cfg_ready is always high.
// ----------------------------------------------------------------------------
module repeating_interval_timer #(
    parameter int TIME_WIDTH   = rit_pkg::TIME_WIDTH_DEF,
    parameter int REPEAT_WIDTH = rit_pkg::REPEAT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  rit_pkg::cmd_item_t                cmd_item,
    output logic                              res_valid,
    input  logic                              res_stall,
    output rit_pkg::res_item_t                res_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rit_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rit_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import rit_pkg::*;

    logic v1_reg;
    logic v1_next;
    logic v2_reg;
    logic v2_next;
    logic out_v_reg;
    logic out_v_next;
    logic en1;
    logic en2;
    logic en3;
    logic take;

    rit_flags_t              flags1;
    logic [REPEAT_WIDTH-1:0] rep1;
    logic [TIME_WIDTH-1:0]   base1;
    logic [TIME_WIDTH-1:0]   interval;

    always_comb
    begin
        en3        = !out_v_reg || !res_stall;
        en2        = !v2_reg || en3;
        en1        = !v1_reg || en2;
        take       = cmd_valid && en1;
        v1_next    = en1 ? take : v1_reg;
        v2_next    = en2 ? v1_reg : v2_reg;
        out_v_next = en3 ? v2_reg : out_v_reg;
    end

    assign cmd_stall = !en1;
    assign res_valid = out_v_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            out_v_reg <= out_v_next;
        end
    end

    rit_core #(
        .TIME_WIDTH   (TIME_WIDTH),
        .REPEAT_WIDTH (REPEAT_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .item         (cmd_item),
        .cfg_we       (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .flags_reg    (flags1),
        .rep_reg      (rep1),
        .base_reg     (base1),
        .interval_reg (interval)
    );

    rit_total #(
        .TIME_WIDTH   (TIME_WIDTH),
        .REPEAT_WIDTH (REPEAT_WIDTH)
    ) u_total (
        .clk      (clk),
        .en2      (en2),
        .en3      (en3),
        .flags_in (flags1),
        .rep_in   (rep1),
        .base_in  (base1),
        .interval (interval),
        .item_reg (res_item)
    );

endmodule

// ===== rtl/rit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rit_checker: port-level checks for the repeating interval timer
// Handshake holds, result latency and timer status consistency.
// ----------------------------------------------------------------------------
module rit_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               cmd_valid,
    input logic               cmd_stall,
    input logic               res_valid,
    input logic               res_stall,
    input rit_pkg::res_item_t res_item
);
    import rit_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(res_item))
        else $error("stalled result changed");

    // a fresh result after an empty output must come from an accepted command
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cmd_valid && !cmd_stall, 3))
        else $error("result without matching command");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_item.is_running && res_item.is_paused) &&
                      (res_item.is_live || !res_item.is_running))
        else $error("inconsistent timer status");

    // once removed, only reset brings the timer back
    a_removed: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_item.is_live |=> !res_valid || !res_item.is_live)
        else $error("removed timer became valid");

endmodule

bind repeating_interval_timer rit_checker u_rit_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
);

// ===== tb/tb_repeating_interval_timer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_repeating_interval_timer: self-checking bench for the interval timer
// Directed command sequences cover countdown, overshoot carry, pause and
// resume, time source selection, negative saturation and removal. Random
// phases follow under several register settings and idle/stall patterns.
// Every result item is compared with a timer model kept inside the bench.
// ----------------------------------------------------------------------------
module tb_repeating_interval_timer;

    import rit_pkg::*;

    localparam int PIPE_LAT    = 3;
    localparam int IDLE_LIMIT  = 4000;
    localparam int MAX_REPORTS = 10;
    localparam int ITEMS_PER_PHASE = 62;
    localparam int NUM_PHASES  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam longint REM_FLOOR = -(longint'(1) << 32);
    localparam longint TOTAL_MAX = (longint'(1) << TOTAL_W) - 1;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cmd_valid = 1'b0;
    logic                   cmd_stall;
    cmd_item_t              cmd_item  = '0;
    logic                   res_valid;
    logic                   res_stall = 1'b0;
    res_item_t              res_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    repeating_interval_timer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int errors        = 0;
    int idle_cycles   = 0;

    res_item_t expected_results[$];

    // timer model: registers and state
    logic [31:0]        tmr_interval = '0;
    logic               tmr_src      = 1'b0;
    logic signed [32:0] tmr_rem      = '0;
    logic               tmr_running  = 1'b0;
    logic               tmr_valid    = 1'b1;
    logic [15:0]        tmr_reps     = '0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        res_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                if (errors < MAX_REPORTS)
                    $display("unexpected result item: %p", res_item);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_item !== want)
                begin
                    if (errors < MAX_REPORTS)
                        $display({"mismatch: exp fired=%0d run=%0d live=%0d paused=%0d ",
                                  "reps=%0d left=%0d | got fired=%0d run=%0d live=%0d ",
                                  "paused=%0d reps=%0d left=%0d"},
                                 want.fired, want.is_running, want.is_live,
                                 want.is_paused, want.repeats_remaining,
                                 want.total_time_left, res_item.fired,
                                 res_item.is_running, res_item.is_live,
                                 res_item.is_paused, res_item.repeats_remaining,
                                 res_item.total_time_left);
                    errors++;
                end
            end
        end
    end

    function automatic logic [TOTAL_W-1:0] time_left_total();
        longint base;
        longint prod;
        if (tmr_reps == 0)
            return '0;
        base = (tmr_rem > 0) ? longint'(tmr_rem) : 0;
        prod = longint'(tmr_reps - 16'd1) * longint'(tmr_interval);
        if (base + prod > TOTAL_MAX)
            return TOTAL_W'(TOTAL_MAX);
        return TOTAL_W'(base + prod);
    endfunction

    // advance the timer model by one command, return the result item
    function automatic res_item_t step_timer(input cmd_item_t c);
        res_item_t   r;
        longint      left;
        logic [31:0] d;
        r = '0;
        case (op_t'(c.operation))
            OP_TICK:
            begin
                if (tmr_running && tmr_valid)
                begin
                    d = tmr_src ? c.delta_real : c.delta_game;
                    left = longint'(tmr_rem) - longint'(d);
                    if (left < REM_FLOOR)
                        left = REM_FLOOR;
                    if (left <= 0)
                    begin
                        r.fired = 1'b1;
                        if (tmr_reps != 0)
                        begin
                            tmr_reps = tmr_reps - 16'd1;
                            if (tmr_reps == 0)
                            begin
                                tmr_valid   = 1'b0;
                                tmr_running = 1'b0;
                                left        = 0;
                            end
                            else
                                left = left + longint'(tmr_interval);
                        end
                        else
                            left = left + longint'(tmr_interval);
                    end
                    tmr_rem = left[32:0];
                end
            end
            OP_START:
            begin
                if (tmr_valid && !tmr_running)
                begin
                    if (tmr_rem == 0)
                        tmr_rem = {1'b0, tmr_interval};
                    tmr_running = 1'b1;
                end
            end
            OP_PAUSE:
                tmr_running = 1'b0;
            default:
            begin
                tmr_running = 1'b0;
                tmr_rem     = '0;
            end
        endcase
        r.is_running        = tmr_running;
        r.is_live           = tmr_valid;
        r.is_paused         = !tmr_running && (tmr_rem != 0);
        r.repeats_remaining = tmr_reps;
        r.total_time_left   = time_left_total();
        return r;
    endfunction

    function automatic cmd_item_t mk_cmd(input op_t op, input logic [31:0] dg,
                                         input logic [31:0] dr);
        cmd_item_t c;
        c.operation  = op;
        c.delta_game = dg;
        c.delta_real = dr;
        return c;
    endfunction

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin send_idle_pct = 59; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 59; end
            3:       begin send_idle_pct = 22; stall_pct = 22; end
            default: begin send_idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // send one command item, record its expected result on acceptance
    task automatic send_cmd(input cmd_item_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        expected_results.insert(expected_results.size(), step_timer(c));
    endtask

    // leaves cfg_valid high so back-to-back writes need no gap
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_INTERVAL:
                tmr_interval = data;
            CFG_REPEAT_COUNT:
                tmr_reps = data[15:0];
            CFG_TIME_SOURCE:
                tmr_src = data[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [31:0] iv, input logic [31:0] rc,
                             input logic [31:0] src);
        write_reg(CFG_INTERVAL, iv);
        write_reg(CFG_REPEAT_COUNT, rc);
        write_reg(CFG_TIME_SOURCE, src);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        cmd_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 2)
            @(posedge clk);
    endtask

    task automatic test_basic_countdown();
        configure(32'd100, {16'hA5C3, 16'd0}, 32'hFFFF_FFFE);
        send_cmd(mk_cmd(OP_TICK, 32'd50, $urandom));      // stopped: ignored
        send_cmd(mk_cmd(OP_START, $urandom, $urandom));   // loads interval
        send_cmd(mk_cmd(OP_START, $urandom, $urandom));   // already running
        send_cmd(mk_cmd(OP_TICK, 32'd30, $urandom));
        send_cmd(mk_cmd(OP_TICK, 32'd70, $urandom));      // lands on zero
        send_cmd(mk_cmd(OP_TICK, 32'd250, $urandom));     // overshoot, goes negative
        send_cmd(mk_cmd(OP_PAUSE, $urandom, $urandom));
        send_cmd(mk_cmd(OP_TICK, 32'd10, $urandom));      // paused: ignored
        send_cmd(mk_cmd(OP_START, $urandom, $urandom));   // resume with negative time
        send_cmd(mk_cmd(OP_TICK, 32'd0, $urandom));       // fires from negative
        send_cmd(mk_cmd(OP_STOP, $urandom, $urandom));
        wait_idle();
    endtask

    task automatic test_time_source();
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
        send_cmd(mk_cmd(OP_STOP, '0, '0));
        send_cmd(mk_cmd(OP_START, '1, '1));
        send_cmd(mk_cmd(OP_TICK, 32'hFFFF_FFFF, 32'd0));  // game delta ignored
        send_cmd(mk_cmd(OP_TICK, 32'd0, 32'hFFFF_FFFF));  // real delta fires
        send_cmd(mk_cmd(OP_PAUSE, '0, '1));
        wait_idle();
    endtask

    task automatic test_saturation();
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);             // no such register
        configure(32'd0, 32'd0, 32'd0);
        send_cmd(mk_cmd(OP_STOP, $urandom, $urandom));
        send_cmd(mk_cmd(OP_START, $urandom, $urandom));
        send_cmd(mk_cmd(OP_TICK, 32'hFFFF_FFFF, $urandom));
        send_cmd(mk_cmd(OP_TICK, 32'hFFFF_FFFF, $urandom)); // hits the negative floor
        send_cmd(mk_cmd(OP_PAUSE, $urandom, $urandom));
        wait_idle();
    endtask

    task automatic test_random_phase(input int n, input int mode);
        logic [31:0] iv;
        logic [31:0] span;
        logic [31:0] junk;
        logic [31:0] dsel;
        logic [31:0] dother;
        logic [15:0] rc;
        int unsigned pick;
        op_t         op;
        pick = $urandom_range(0, 7);
        case (pick)
            0:       iv = 32'd0;
            1:       iv = 32'hFFFF_FFFF;
            2:       iv = $urandom;
            default: iv = $urandom_range(1, 5000);
        endcase
        // counts of 600 and up cannot run out within one phase
        if ($urandom_range(0, 1) == 0)
            rc = 16'd0;
        else if ($urandom_range(0, 3) == 0)
            rc = 16'hFFFF;
        else
            rc = 16'($urandom_range(600, 65535));
        junk = $urandom;
        configure(iv, {junk[31:16], rc}, {junk[15:1], 1'($urandom_range(0, 1))});
        set_idling(mode);
        span = (iv == 0 || iv > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : iv * 2;
        repeat (n)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 13)
                op = OP_TICK;
            else if (pick < 16)
                op = OP_START;
            else if (pick < 18)
                op = OP_PAUSE;
            else
                op = OP_STOP;
            dsel   = ($urandom_range(0, 6) == 0) ? $urandom : $urandom_range(0, span);
            dother = $urandom;
            if (tmr_src)
                send_cmd(mk_cmd(op, dother, dsel));
            else
                send_cmd(mk_cmd(op, dsel, dother));
        end
        wait_idle();
        set_idling(0);
    endtask

    // runs last: only reset brings a removed timer back
    task automatic test_removal();
        configure(32'd40, 32'd3, 32'd0);
        send_cmd(mk_cmd(OP_STOP, $urandom, $urandom));
        send_cmd(mk_cmd(OP_START, $urandom, $urandom));
        send_cmd(mk_cmd(OP_TICK, 32'd40, $urandom));
        send_cmd(mk_cmd(OP_TICK, 32'd100, $urandom));
        send_cmd(mk_cmd(OP_TICK, 32'd0, $urandom));       // last repeat: removed
        send_cmd(mk_cmd(OP_TICK, 32'd50, $urandom));
        send_cmd(mk_cmd(OP_START, $urandom, $urandom));
        send_cmd(mk_cmd(OP_PAUSE, $urandom, $urandom));
        send_cmd(mk_cmd(OP_STOP, $urandom, $urandom));
        wait_idle();
        write_reg(CFG_REPEAT_COUNT, 32'd5);               // does not revive it
        cfg_valid <= 1'b0;
        send_cmd(mk_cmd(OP_TICK, 32'd50, $urandom));
        send_cmd(mk_cmd(OP_START, $urandom, $urandom));
        wait_idle();
    endtask

    initial
    begin
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_countdown();
        test_time_source();
        test_saturation();
        for (int p = 0; p < NUM_PHASES; p++)
            test_random_phase(ITEMS_PER_PHASE, p % 4);
        test_removal();

        if (errors == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
